FILE: design/adcdc_pkg.sv
// ----------------------------------------------------------------------------
// adcdc_pkg
// Shared types and constants of the dc blocker and pcm packer.
// ----------------------------------------------------------------------------
`default_nettype none

package adcdc_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_COEF_R       = 2'd0;
  localparam logic [1:0] REG_GAIN         = 2'd1;
  localparam logic [1:0] REG_INPUT_FORMAT = 2'd2;
  localparam logic [1:0] REG_CLAMP_LIMIT  = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // reset values and limits
  localparam logic [15:0] COEF_R_RESET      = 16'd64514;
  localparam logic [15:0] COEF_R_MAX        = 16'd65529;
  localparam logic [15:0] GAIN_RESET        = 16'd4096;
  localparam logic        FORMAT_RESET      = 1'b0;
  localparam logic [14:0] CLAMP_LIMIT_RESET = 15'd32734;

  // input word formats
  localparam logic FMT_ADC_FRAME = 1'b0;
  localparam logic FMT_PCM16     = 1'b1;

  typedef struct packed {
    logic [15:0] coef_r;
    logic [15:0] gain;
    logic        input_format;
    logic [14:0] clamp_limit;
  } cfg_t;

  // controller commands to the datapath
  typedef struct packed {
    logic load;      // take the input word, form x and the difference
    logic mul_fb;    // product = prev_output * coef_r
    logic update;    // y = diff + rounded feedback, saturated
    logic mul_gain;  // product = y * gain
    logic emit;      // round, clamp and load the output register
  } cmd_t;

endpackage : adcdc_pkg

`default_nettype wire

FILE: design/adcdc_cfg_regs.sv
// ----------------------------------------------------------------------------
// adcdc_cfg_regs
// Configuration register file with pole radius saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module adcdc_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [adcdc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [adcdc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output adcdc_pkg::cfg_t                          cfg
);
  import adcdc_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.coef_r       <= COEF_R_RESET;
      regs.gain         <= GAIN_RESET;
      regs.input_format <= FORMAT_RESET;
      regs.clamp_limit  <= CLAMP_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COEF_R:       regs.coef_r <= (cfg_data > COEF_R_MAX) ? COEF_R_MAX : cfg_data;
        REG_GAIN:         regs.gain <= cfg_data;
        REG_INPUT_FORMAT: regs.input_format <= cfg_data[0];
        REG_CLAMP_LIMIT:  regs.clamp_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule : adcdc_cfg_regs

`default_nettype wire

FILE: design/adcdc_ctrl.sv
// ----------------------------------------------------------------------------
// adcdc_ctrl
// Sequencer: steps one item through the shared multiplier and drives the
// handshakes of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module adcdc_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sample_valid,
  output      logic        sample_stall,
  output      logic        pcm_valid,
  input  wire logic        pcm_stall,
  output adcdc_pkg::cmd_t  cmd
);
  import adcdc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FB   = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_GAIN = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  // output register can take a result when empty or being drained
  assign out_free     = !pcm_valid || !pcm_stall;
  assign sample_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = S_FB;
        end
      end
      S_FB: begin
        cmd.mul_fb = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.update = 1'b1;
        state_next = S_GAIN;
      end
      S_GAIN: begin
        cmd.mul_gain = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pcm_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        pcm_valid <= 1'b1;
      end else if (!pcm_stall) begin
        pcm_valid <= 1'b0;
      end
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.mul_fb, cmd.update, cmd.mul_gain, cmd.emit}))
    else $error("more than one datapath command at once");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> pcm_valid)
    else $error("emitted result not presented");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_FB))
    else $error("accepted item did not start the feedback multiply");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && pcm_valid && pcm_stall) |=> (state == S_OUT))
    else $error("finished result dropped while output register full");

endmodule : adcdc_ctrl

`default_nettype wire

FILE: design/adcdc_datapath.sv
// ----------------------------------------------------------------------------
// adcdc_datapath
// Input decode, filter state, shared multiplier, rounding, clamp and the
// packet position counter.
// ----------------------------------------------------------------------------
`default_nettype none

module adcdc_datapath #(
  parameter int PACKET_SAMPLES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire adcdc_pkg::cmd_t    cmd,
  input  wire adcdc_pkg::cfg_t    cfg,
  input  wire logic [15:0]        sample_word,
  output      logic signed [15:0] pcm_sample,
  output      logic               last_in_packet
);
  import adcdc_pkg::*;

  localparam int PW = (PACKET_SAMPLES > 1) ? $clog2(PACKET_SAMPLES) : 1;
  localparam logic [PW-1:0] POS_LAST = PW'(PACKET_SAMPLES - 1);

  logic signed [15:0] x;
  logic signed [15:0] prev_input;
  logic signed [31:0] prev_output;
  logic               primed;
  logic signed [16:0] diff;
  logic signed [16:0] mul_b;
  logic signed [48:0] product;
  logic signed [48:0] fb_sum;
  logic signed [32:0] fb;
  logic signed [33:0] y_wide;
  logic signed [31:0] y_sat;
  logic signed [48:0] g_sum;
  logic signed [28:0] s_wide;
  logic signed [28:0] lim;
  logic signed [28:0] s_clamped;
  logic [PW-1:0]      pkt_pos;

  // adc frame: 12-bit code from the two spi bytes, centered and scaled by 16
  always_comb begin
    if (cfg.input_format == FMT_PCM16) begin
      x = signed'(sample_word);
    end else begin
      x = {~sample_word[12], sample_word[11:8], sample_word[7:1], 4'b0000};
    end
  end

  assign mul_b = cmd.mul_fb ? signed'({1'b0, cfg.coef_r}) : signed'({1'b0, cfg.gain});

  // feedback rounded to q8.23, half up
  assign fb_sum = product + 49'sd32768;
  assign fb     = fb_sum[48:16];
  assign y_wide = {{9{diff[16]}}, diff, 8'b0} + {fb[32], fb};

  always_comb begin
    if (y_wide[33:31] == 3'b000 || y_wide[33:31] == 3'b111) begin
      y_sat = y_wide[31:0];
    end else if (y_wide[33]) begin
      y_sat = 32'sh8000_0000;
    end else begin
      y_sat = 32'sh7FFF_FFFF;
    end
  end

  // gained output rounded to q1.15, half up, then clamped
  assign g_sum  = product + 49'sd524288;
  assign s_wide = g_sum[48:20];
  assign lim    = signed'({14'b0, cfg.clamp_limit});

  always_comb begin
    priority if (s_wide > lim) begin
      s_clamped = lim;
    end else if (s_wide < -lim) begin
      s_clamped = -lim;
    end else begin
      s_clamped = s_wide;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_output <= '0;
      primed      <= 1'b0;
      pkt_pos     <= '0;
    end else begin
      if (cmd.load) begin
        primed <= 1'b1;
      end
      if (cmd.update) begin
        prev_output <= y_sat;
      end
      if (cmd.emit) begin
        pkt_pos <= (pkt_pos == POS_LAST) ? '0 : pkt_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      diff       <= primed ? ({x[15], x} - {prev_input[15], prev_input}) : '0;
      prev_input <= x;
    end
    if (cmd.mul_fb || cmd.mul_gain) begin
      product <= prev_output * mul_b;
    end
    if (cmd.emit) begin
      pcm_sample     <= s_clamped[15:0];
      last_in_packet <= (pkt_pos == POS_LAST);
    end
  end

endmodule : adcdc_datapath

`default_nettype wire

FILE: design/adc_dc_block_pcm_packer.sv
// ----------------------------------------------------------------------------
// adc_dc_block_pcm_packer
// First-order dc blocker with gain, clamp and packet marking for audio words.
// ----------------------------------------------------------------------------
// usage
//   input channel: sample_word with sample_valid / sample_stall; one item is
//   taken when valid is high and stall is low. the word is a two-byte adc
//   spi frame or a signed 16-bit sample, chosen by input_format.
//   output channel: pcm_sample and last_in_packet with pcm_valid / pcm_stall.
//   config: cfg_write, cfg_index, cfg_data; write only while idle.
// timing
//   an item runs through five steps of the sequencer: accept, feedback
//   multiply, filter add, gain multiply, round/clamp. the single shared
//   multiplier sets this, so the block takes no new item until the current
//   one has left the round/clamp step, which loads the output register.
//   the next item is accepted while a result still waits in the output
//   register; a stalled receiver holds the finished item in the last step.
// reset
//   rst (synchronous) restores the register defaults, clears the filter
//   state and packet position; the first item after reset primes the filter
//   and gives a zero output.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_dc_block_pcm_packer #(
  parameter int PACKET_SAMPLES = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // input items
  input  wire logic                               sample_valid,
  output      logic                               sample_stall,
  input  wire logic [15:0]                        sample_word,
  // result items
  output      logic                               pcm_valid,
  input  wire logic                               pcm_stall,
  output      logic signed [15:0]                 pcm_sample,
  output      logic                               last_in_packet,
  // configuration writes
  input  wire logic                               cfg_write,
  input  wire logic [adcdc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [adcdc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import adcdc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  // register file, coef_r saturates at 0.9999
  adcdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer and handshakes
  adcdc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .pcm_valid    (pcm_valid),
    .pcm_stall    (pcm_stall),
    .cmd          (cmd)
  );

  // filter state, shared multiplier and output register
  adcdc_datapath #(
    .PACKET_SAMPLES (PACKET_SAMPLES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .sample_word    (sample_word),
    .pcm_sample     (pcm_sample),
    .last_in_packet (last_in_packet)
  );

endmodule : adc_dc_block_pcm_packer

`default_nettype wire
